@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies; the enclosing scope must provide clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GDOY_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GDOY_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/gdoy_pkg.sv @@
// Shared types, constants and the month offset table for the day-of-year converter.
// No dependencies.
package gdoy_pkg;

   localparam logic       ModeToYearDay  = 1'b0;
   localparam logic       ModeToMonthDay = 1'b1;

   localparam logic [3:0]  MonthMax    = 4'd12;
   localparam logic [8:0]  YearDayMax  = 9'd366;
   localparam logic [15:0] Recip25     = 16'd41944;  // ceil(2^20 / 25)
   localparam int          RecipShift  = 20;
   localparam int          ProdWidth   = 31;
   localparam int          QuotWidth   = ProdWidth - RecipShift;

   typedef struct packed {
      logic       mode;
      logic [3:0] month;
      logic [5:0] day;
      logic [8:0] year_day;
      logic       err;
   } gdoy_item_type;

   // Days before the first of a month; zero for codes outside 1..12.
   function automatic logic [8:0] days_before(input logic leap, input logic [3:0] month);
      logic [8:0] base;
      case (month)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + 9'((leap && month > 4'd2 && month <= MonthMax) ? 1 : 0);
   endfunction

endpackage

@@ sv/gdoy_screen.sv @@
// Stage 1: range checks on the request and the reciprocal product for the divide-by-25 test.
// Depends on gdoy_pkg.
module gdoy_screen (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic                                  mode,
   input  logic signed [15:0]                    year,
   input  logic [3:0]                            month,
   input  logic [5:0]                            day,
   input  logic [8:0]                            year_day,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output gdoy_pkg::gdoy_item_type               out_item,
   output logic [14:0]                           out_year,
   output logic [gdoy_pkg::ProdWidth-1:0]        out_prod
);

   logic                                 valid_ff;
   gdoy_pkg::gdoy_item_type              item_ff, item_in;
   logic [14:0]                          year_ff;
   logic [gdoy_pkg::ProdWidth-1:0]       prod_ff, prod_in;
   logic                                 range_err;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (mode == gdoy_pkg::ModeToYearDay) begin
         range_err = (month == 4'd0) || (month > gdoy_pkg::MonthMax) ||
                     (day == 6'd0) || day[5];
      end else begin
         range_err = (year_day == 9'd0) || (year_day > gdoy_pkg::YearDayMax);
      end
      item_in.mode     = mode;
      item_in.month    = month;
      item_in.day      = day;
      item_in.year_day = year_day;
      item_in.err      = year[15] || range_err;
      prod_in = gdoy_pkg::ProdWidth'(year[14:0]) * gdoy_pkg::ProdWidth'(gdoy_pkg::Recip25);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
         year_ff <= year[14:0];
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_year  = year_ff;
   assign out_prod  = prod_ff;

endmodule

@@ sv/gdoy_leap.sv @@
// Stage 2: leap-year decision from the low year bits and the divide-by-25 check.
// Depends on gdoy_pkg.
module gdoy_leap (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  gdoy_pkg::gdoy_item_type               in_item,
   input  logic [14:0]                           in_year,
   input  logic [gdoy_pkg::ProdWidth-1:0]        in_prod,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output gdoy_pkg::gdoy_item_type               out_item,
   output logic                                  out_leap
);

   logic                                 valid_ff;
   gdoy_pkg::gdoy_item_type              item_ff;
   logic                                 leap_ff, leap_in;
   logic [gdoy_pkg::QuotWidth-1:0]       quot;
   logic [15:0]                          quot_x25;
   logic                                 div25;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      quot     = in_prod[gdoy_pkg::ProdWidth-1:gdoy_pkg::RecipShift];
      quot_x25 = 16'({quot, 4'b0000}) + 16'({quot, 3'b000}) + 16'(quot);
      div25    = (quot_x25 == {1'b0, in_year});
      leap_in  = (in_year[1:0] == 2'b00) && (!div25 || (in_year[3:0] == 4'b0000));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
         leap_ff <= leap_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_leap  = leap_ff;

endmodule

@@ sv/gdoy_month.sv @@
// Stage 3: month search for the day-of-year direction by parallel compares on month offsets.
// Depends on gdoy_pkg.
module gdoy_month (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  gdoy_pkg::gdoy_item_type               in_item,
   input  logic                                  in_leap,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output gdoy_pkg::gdoy_item_type               out_item,
   output logic                                  out_leap,
   output logic [3:0]                            out_month
);

   logic                                 valid_ff;
   gdoy_pkg::gdoy_item_type              item_ff;
   logic                                 leap_ff;
   logic [3:0]                           month_ff, month_in;

   assign in_ready = !valid_ff || out_ready;

   // Offsets rise with the month, so the last hit is the answer.
   always_comb begin
      month_in = 4'd1;
      for (int k = 2; k <= 12; k++) begin
         if (in_item.year_day > gdoy_pkg::days_before(in_leap, 4'(k))) begin
            month_in = 4'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff  <= in_item;
         leap_ff  <= in_leap;
         month_ff <= month_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_leap  = leap_ff;
   assign out_month = month_ff;

endmodule

@@ sv/gdoy_finish.sv @@
// Stage 4: final results and error masking, held in the response register.
// Depends on gdoy_pkg.
module gdoy_finish (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  gdoy_pkg::gdoy_item_type               in_item,
   input  logic                                  in_leap,
   input  logic [3:0]                            in_month,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic                                  out_error,
   output logic [8:0]                            out_day_number,
   output logic [3:0]                            out_month_out,
   output logic [4:0]                            out_day_out
);

   logic                                 valid_ff;
   logic                                 error_ff, error_in;
   logic [8:0]                           day_number_ff, day_number_in;
   logic [3:0]                           month_out_ff, month_out_in;
   logic [4:0]                           day_out_ff, day_out_in;
   logic [8:0]                           offset;
   logic [8:0]                           remain;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (in_item.mode == gdoy_pkg::ModeToYearDay) begin
         offset = gdoy_pkg::days_before(in_leap, in_item.month);
      end else begin
         offset = gdoy_pkg::days_before(in_leap, in_month);
      end
      remain   = in_item.year_day - offset;
      error_in = in_item.err ||
                 ((in_item.mode == gdoy_pkg::ModeToMonthDay) &&
                  (in_item.year_day == gdoy_pkg::YearDayMax) && !in_leap);
      day_number_in = 9'd0;
      month_out_in  = 4'd0;
      day_out_in    = 5'd0;
      if (!error_in) begin
         if (in_item.mode == gdoy_pkg::ModeToYearDay) begin
            day_number_in = offset + 9'(in_item.day);
         end else begin
            month_out_in = in_month;
            day_out_in   = remain[4:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         error_ff      <= error_in;
         day_number_ff <= day_number_in;
         month_out_ff  <= month_out_in;
         day_out_ff    <= day_out_in;
      end
   end

   assign out_valid      = valid_ff;
   assign out_error      = error_ff;
   assign out_day_number = day_number_ff;
   assign out_month_out  = month_out_ff;
   assign out_day_out    = day_out_ff;

endmodule

@@ sv/gregorian_day_of_year_convert_core.sv @@
// Top level of the Gregorian day-of-year converter: four-stage pipeline.
// Depends on gdoy_pkg, gdoy_screen, gdoy_leap, gdoy_month, gdoy_finish.
//
//   channel   direction   ports                                           per transfer
//   req       in          req_valid, req_stall, mode/year/month/day/...   one date
//   rsp       out         rsp_valid, rsp_stall, error/day_number/...      one result
//
// rsp_valid rises once the request has passed the screen, leap, month and finish registers;
// one transfer per cycle while rsp_stall is low. The leap test (reciprocal multiply for
// divide-by-25) sets the split into four stages. Reset is synchronous and clears only the stage valid bits.
// Each stage holds while the next is full and stalled; empty stages still fill.
module gregorian_day_of_year_convert_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic signed [15:0]   req_year,
   input  logic [3:0]           req_month,
   input  logic [5:0]           req_day,
   input  logic [8:0]           req_year_day,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_error,
   output logic [8:0]           rsp_day_number,
   output logic [3:0]           rsp_month_out,
   output logic [4:0]           rsp_day_out
);

   logic                              s1_valid, s1_ready;
   gdoy_pkg::gdoy_item_type           s1_item;
   logic [14:0]                       s1_year;
   logic [gdoy_pkg::ProdWidth-1:0]    s1_prod;
   logic                              s2_valid, s2_ready;
   gdoy_pkg::gdoy_item_type           s2_item;
   logic                              s2_leap;
   logic                              s3_valid, s3_ready;
   gdoy_pkg::gdoy_item_type           s3_item;
   logic                              s3_leap;
   logic [3:0]                        s3_month;
   logic                              s4_ready;
   logic                              req_ready;

   assign req_stall = !req_ready;

   gdoy_screen u_screen (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .mode      (req_mode),
      .year      (req_year),
      .month     (req_month),
      .day       (req_day),
      .year_day  (req_year_day),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_item  (s1_item),
      .out_year  (s1_year),
      .out_prod  (s1_prod)
   );

   gdoy_leap u_leap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_item   (s1_item),
      .in_year   (s1_year),
      .in_prod   (s1_prod),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_item  (s2_item),
      .out_leap  (s2_leap)
   );

   gdoy_month u_month (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_item   (s2_item),
      .in_leap   (s2_leap),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_item  (s3_item),
      .out_leap  (s3_leap),
      .out_month (s3_month)
   );

   assign s4_ready = !rsp_stall;

   gdoy_finish u_finish (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s3_valid),
      .in_ready       (s3_ready),
      .in_item        (s3_item),
      .in_leap        (s3_leap),
      .in_month       (s3_month),
      .out_valid      (rsp_valid),
      .out_ready      (s4_ready),
      .out_error      (rsp_error),
      .out_day_number (rsp_day_number),
      .out_month_out  (rsp_month_out),
      .out_day_out    (rsp_day_out)
   );

endmodule

@@ sv/gdoy_checker.sv @@
// Port-level checks on the response channel of the day-of-year converter, bound to the top.
// Depends on assert_macros.svh and gregorian_day_of_year_convert_core.
`include "assert_macros.svh"

module gdoy_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_mode,
   input  logic signed [15:0]   req_year,
   input  logic [3:0]           req_month,
   input  logic [5:0]           req_day,
   input  logic [8:0]           req_year_day,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_error,
   input  logic [8:0]           rsp_day_number,
   input  logic [3:0]           rsp_month_out,
   input  logic [4:0]           rsp_day_out
);

   `GDOY_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_error) && $stable(rsp_day_number) && $stable(rsp_month_out) && $stable(rsp_day_out), "stalled response changed")

   `GDOY_ASSERT_NOW(a_err_zero, rsp_valid && rsp_error, rsp_day_number == 9'd0 && rsp_month_out == 4'd0 && rsp_day_out == 5'd0, "error response with nonzero fields")

   `GDOY_ASSERT_NOW(a_one_dir, rsp_valid && !rsp_error, (rsp_day_number == 9'd0) != (rsp_month_out == 4'd0), "response must carry exactly one direction")

   `GDOY_ASSERT_NOW(a_md_range, rsp_valid && !rsp_error && rsp_month_out != 4'd0, rsp_month_out <= 4'd12 && rsp_day_out != 5'd0 && rsp_day_number == 9'd0, "month/day result out of range")

   `GDOY_ASSERT_NOW(a_yd_range, rsp_valid && !rsp_error && rsp_month_out == 4'd0, rsp_day_number <= 9'd366 && rsp_day_out == 5'd0, "day-of-year result out of range")

endmodule

bind gregorian_day_of_year_convert_core gdoy_checker u_gdoy_checker (.*);

@@ sim/tb_gregorian_day_of_year_convert_core.sv @@
// Self-checking bench for gregorian_day_of_year_convert_core: directed and random dates in
// both modes, random idling on both channels, one long response hold-off to fill the pipe.
// Depends on gdoy_pkg and the core; the expected results come from a date tracker class.

typedef struct {
   logic               mode;
   logic signed [15:0] year;
   logic [3:0]         month;
   logic [5:0]         day;
   logic [8:0]         year_day;
} date_request;

typedef struct {
   logic       error;
   logic [8:0] day_number;
   logic [3:0] month_out;
   logic [4:0] day_out;
} date_conversion;

class date_tracker;
   date_conversion pending_conv[$];
   int             mismatches;

   function new();
      mismatches = 0;
   endfunction

   function int unsigned month_days(int unsigned m, bit leap);
      case (m)
         2:           return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function date_conversion convert(date_request d);
      date_conversion r;
      int unsigned    y;
      int unsigned    acc;
      int unsigned    m;
      bit             leap;
      r = '{error: 1'b0, day_number: 9'd0, month_out: 4'd0, day_out: 5'd0};
      if (d.year[15]) begin
         r.error = 1'b1;
      end else begin
         y    = int'(d.year);
         leap = ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
         if (d.mode == gdoy_pkg::ModeToYearDay) begin
            if (d.month < 1 || d.month > 12 || d.day < 1 || d.day > 31) begin
               r.error = 1'b1;
            end else begin
               acc = d.day;
               for (m = 1; m < d.month; m++) acc += month_days(m, leap);
               r.day_number = 9'(acc);
            end
         end else begin
            if (d.year_day < 1 || d.year_day > 365 + leap) begin
               r.error = 1'b1;
            end else begin
               acc = d.year_day;
               m   = 1;
               while (m < 12 && acc > month_days(m, leap)) begin
                  acc -= month_days(m, leap);
                  m++;
               end
               r.month_out = 4'(m);
               r.day_out   = 5'(acc);
            end
         end
      end
      return r;
   endfunction

   function void note_date(date_request d);
      pending_conv.push_back(convert(d));
   endfunction

   function void check_conversion(logic err, logic [8:0] dnum, logic [3:0] mout,
                                  logic [4:0] dout);
      date_conversion e;
      if (pending_conv.size() == 0) begin
         $error("response transfer with no request outstanding");
         mismatches++;
         return;
      end
      e = pending_conv.pop_front();
      if (err !== e.error) begin
         $error("error expected %0d actual %0d", e.error, err);
         mismatches++;
      end
      if (dnum !== e.day_number) begin
         $error("day_number expected %0d actual %0d", e.day_number, dnum);
         mismatches++;
      end
      if (mout !== e.month_out) begin
         $error("month_out expected %0d actual %0d", e.month_out, mout);
         mismatches++;
      end
      if (dout !== e.day_out) begin
         $error("day_out expected %0d actual %0d", e.day_out, dout);
         mismatches++;
      end
   endfunction
endclass

module tb_gregorian_day_of_year_convert_core;
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_mode;
   logic signed [15:0] req_year;
   logic [3:0]         req_month;
   logic [5:0]         req_day;
   logic [8:0]         req_year_day;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_error;
   logic [8:0]         rsp_day_number;
   logic [3:0]         rsp_month_out;
   logic [4:0]         rsp_day_out;

   date_tracker tracker;
   date_request directed[$];
   bit          steady;
   int          accepted_count;

   gregorian_day_of_year_convert_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_year       (req_year),
      .req_month      (req_month),
      .req_day        (req_day),
      .req_year_day   (req_year_day),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_error      (rsp_error),
      .rsp_day_number (rsp_day_number),
      .rsp_month_out  (rsp_month_out),
      .rsp_day_out    (rsp_day_out)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #400000;
      $display("gregorian_day_of_year_convert_core regression: fail");
      $finish;
   end

   function automatic date_request make_date(logic mode, int year, int month, int day,
                                             int yday);
      date_request d;
      d.mode     = mode;
      d.year     = 16'(year);
      d.month    = 4'(month);
      d.day      = 6'(day);
      d.year_day = 9'(yday);
      return d;
   endfunction

   function automatic date_request random_date();
      date_request d;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 10)      d.year = 16'($urandom);
      else if (pick < 20) d.year = 16'(400 * $urandom_range(0, 81));
      else if (pick < 35) d.year = 16'(100 * $urandom_range(0, 327));
      else if (pick < 55) d.year = 16'(4 * $urandom_range(0, 8191));
      else                d.year = 16'($urandom_range(0, 32767));
      d.mode  = 1'($urandom_range(1));
      d.month = ($urandom_range(99) < 88) ? 4'($urandom_range(1, 12)) : 4'($urandom);
      d.day   = ($urandom_range(99) < 85) ? 6'($urandom_range(1, 31)) : 6'($urandom);
      pick = $urandom_range(99);
      if (pick < 12)      d.year_day = 9'($urandom_range(358, 367));
      else if (pick < 85) d.year_day = 9'($urandom_range(1, 366));
      else                d.year_day = 9'($urandom);
      return d;
   endfunction

   task automatic drive_date(input date_request d);
      while (!steady && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= d.mode;
      req_year     <= d.year;
      req_month    <= d.month;
      req_day      <= d.day;
      req_year_day <= d.year_day;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_date(d);
      accepted_count++;
   endtask

   // response side: random stall plus one long hold-off while requests keep coming
   initial begin
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            tracker.check_conversion(rsp_error, rsp_day_number, rsp_month_out, rsp_day_out);
         if (!hold_done && accepted_count >= 150) begin
            hold_done = 1;
            hold_left = 60;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (steady) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 13);
         end
      end
   end

   initial begin
      tracker        = new();
      steady         = 0;
      accepted_count = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_mode     <= 1'b0;
      req_year     <= '0;
      req_month    <= '0;
      req_day      <= '0;
      req_year_day <= '0;
      rsp_stall    <= 1'b0;

      // mode 0: extremes, leap rules, unchecked month length, bad fields
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 0, 1, 1, 511));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 2000, 12, 31, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 1900, 12, 31, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 2023, 2, 31, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 2024, 2, 31, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 2024, 3, 1, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 32767, 7, 15, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 2023, 0, 10, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 2023, 13, 10, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 2023, 15, 63, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 2023, 6, 0, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, 2023, 6, 32, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToYearDay, -32768, 5, 5, 0));
      // mode 1: day-of-year bounds, leap day, negative year, century years
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 2023, 15, 63, 1));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 2023, 0, 0, 0));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 2023, 0, 0, 365));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 2023, 0, 0, 366));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 2024, 0, 0, 366));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 2024, 0, 0, 60));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 2023, 0, 0, 60));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 2100, 0, 0, 366));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 0, 0, 0, 366));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 2023, 0, 0, 367));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, 32767, 0, 0, 511));
      directed.push_back(make_date(gdoy_pkg::ModeToMonthDay, -1, 0, 0, 100));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) drive_date(directed[i]);
      for (int i = 0; i < 500; i++) begin
         steady = (i >= 250 && i < 350);
         drive_date(random_date());
      end
      steady = 0;
      req_valid <= 1'b0;

      while (tracker.pending_conv.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_conv.size() == 0)
         $display("gregorian_day_of_year_convert_core regression: pass");
      else
         $display("gregorian_day_of_year_convert_core regression: fail");
      $finish;
   end
endmodule

@@ gregorian_day_of_year_convert_core.f @@
+incdir+sv
sv/gdoy_pkg.sv
sv/gdoy_screen.sv
sv/gdoy_leap.sv
sv/gdoy_month.sv
sv/gdoy_finish.sv
sv/gregorian_day_of_year_convert_core.sv
sv/gdoy_checker.sv
sim/tb_gregorian_day_of_year_convert_core.sv
